@@ rtl/core/sprc_pkg.sv @@
package sprc_pkg;

	localparam int VIDEO_MEMORY_BYTES = 32768;
	localparam int SCREEN_WIDTH       = 400;
	localparam int SCREEN_HEIGHT      = 300;
	localparam int SPRITE_COUNT       = 256;
	localparam int SPRITE_TABLE_BASE  = 12288;
	localparam int SPRITE_IMAGE_BASE  = 16384;

	localparam int VMEM_AW     = $clog2(VIDEO_MEMORY_BYTES);
	localparam int OWNER_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int OWN_AW      = $clog2(OWNER_DEPTH);
	localparam int CLR_LEN     = (OWNER_DEPTH > VIDEO_MEMORY_BYTES) ?
		OWNER_DEPTH : VIDEO_MEMORY_BYTES;
	localparam int CLR_W       = $clog2(CLR_LEN);

	// Fixed device map
	localparam int ADDR_JK_MODE = 32'h2808;
	localparam int ADDR_PAL16_A = 32'h2840;
	localparam int ADDR_PAL16_B = 32'h2860;
	localparam int ADDR_PAL4_A  = 32'h2880;
	localparam int ADDR_PAL4_B  = 32'h2888;
	localparam int ADDR_COLLIDE = 32'h2900;
	localparam int ADDR_PAL256  = 32'h3800;

	localparam logic [8:0] OWNER_EMPTY = 9'h1ff;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_RENDER = 2'd2,
		CMD_FRAME  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_WR,
		ST_RD,
		ST_RD_D,
		ST_REC,
		ST_REC_D,
		ST_POS,
		ST_IMG,
		ST_CLO,
		ST_CHI,
		ST_OWN,
		ST_JK,
		ST_OUT
	} state_t;

endpackage

@@ rtl/core/sprc_ram.sv @@
module sprc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/sprite_rasterizer_with_collision.sv @@
// Sprite rasterizer with collision detection. The host writes (cmd 0) and reads
// (cmd 1) the byte-wide video memory; a read returns one transaction with last set.
// Render (cmd 2) decodes the 4-byte record of one sprite and draws one 16-pixel
// source row, returning 16 transactions in source order, last on the sixteenth;
// opaque on-screen pixels update the pixel-owner map and the collision table.
// Start frame (cmd 3) empties the owner map and fills the collision table with
// 0xff. Every video memory access goes through a single port with registered read
// data. A render fetches the four record bytes and the jk mode byte, then for each
// pixel reads the image byte, the color low and high bytes and the owner entry and,
// over an owned pixel, reads the other sprite's jk bit and may write the collision
// table; off-screen pixels skip the reads and transparent pixels stop after the color.
// After reset and after every start frame the block sweeps the owner map one entry a
// cycle with in_stall high; the reset sweep also zeroes the video memory.
module sprite_rasterizer_with_collision (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [14:0] address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  sprite_index,
	input  logic [3:0]  source_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [8:0]  pixel_x,
	output logic [8:0]  pixel_y,
	output logic [14:0] color,
	output logic        pixel_drawn,
	output logic        last
);

	localparam int AW = sprc_pkg::VMEM_AW;
	localparam int OW = sprc_pkg::OWN_AW;
	localparam int CW = sprc_pkg::CLR_W;

	sprc_pkg::state_t state_q, nxt;
	sprc_pkg::cmd_t   cmd_q;

	logic [14:0]   addr_q;
	logic [7:0]    wdata_q;
	logic [7:0]    spr_q;
	logic [3:0]    row_q;
	logic [CW-1:0] sweep_q;
	logic          wipe_all_q;
	logic [2:0]    k_q;
	logic [31:0]   rec_q;
	logic          jkmode_q;
	logic [3:0]    sx_q;
	logic [8:0]    wx_q, wy_q;
	logic [OW-1:0] cell_q;
	logic [AW-1:0] ca_q;
	logic [15:0]   color_q;
	logic [8:0]    other_q;
	logic          drawn_q;

	logic          out_valid_q;
	logic [7:0]    read_data_q;
	logic [8:0]    pixel_x_q, pixel_y_q;
	logic [14:0]   color_out_q;
	logic          pixel_drawn_q, last_q;

	// Memory ports
	logic          vm_we;
	logic [AW-1:0] vm_addr;
	logic [7:0]    vm_wdata, vm_rdata;
	logic          ow_we;
	logic [OW-1:0] ow_addr;
	logic [8:0]    ow_wdata, ow_rdata;

	logic accept, can_load, out_load;

	// Record decode
	logic [8:0] spr_x, spr_y;
	logic [2:0] rot;
	logic [3:0] pal;
	logic [5:0] image;
	logic       jk;

	logic [3:0]    rx, ry;
	logic [8:0]    wx, wy;
	logic          onscreen;
	logic [OW-1:0] cell_idx;
	logic [AW-1:0] img_addr, pal_addr, rec_addr, jk2_addr, coll_addr, sweep_addr;
	logic [31:0]   pal_base;
	logic [2:0]    shift;
	logic [7:0]    mask, idx;
	logic          sweep_own, sweep_vm, sweep_end, collide;

	sprc_ram #(.WIDTH(8), .DEPTH(sprc_pkg::VIDEO_MEMORY_BYTES)) u_vmem (
		.clk   (clk),
		.we    (vm_we),
		.addr  (vm_addr),
		.wdata (vm_wdata),
		.rdata (vm_rdata)
	);

	sprc_ram #(.WIDTH(9), .DEPTH(sprc_pkg::OWNER_DEPTH)) u_owner (
		.clk   (clk),
		.we    (ow_we),
		.addr  (ow_addr),
		.wdata (ow_wdata),
		.rdata (ow_rdata)
	);

	assign accept   = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;

	assign spr_x = {rec_q[8], rec_q[7:0]};
	assign rot   = rec_q[11:9];
	assign pal   = rec_q[15:12];
	assign spr_y = {rec_q[24], rec_q[23:16]};
	assign image = rec_q[30:25];
	assign jk    = rec_q[31];

	// Flip and transpose the source coordinate, then wrap at 9 bits
	always_comb begin
		rx = rot[1] ? ~sx_q : sx_q;
		ry = rot[2] ? ~row_q : row_q;
		if (rot[0]) begin
			rx = ry;
			ry = rot[1] ? ~sx_q : sx_q;
		end
	end

	assign wx       = spr_x + {5'd0, rx};
	assign wy       = spr_y + {5'd0, ry};
	assign onscreen = ({1'b0, wx} < 10'(sprc_pkg::SCREEN_WIDTH)) &&
		({1'b0, wy} < 10'(sprc_pkg::SCREEN_HEIGHT));
	assign cell_idx = OW'({23'd0, wy} * 32'(sprc_pkg::SCREEN_WIDTH) + {23'd0, wx});

	// Palette mode: 2-bit with 4 selects, 4-bit with 2 selects, else 8-bit
	always_comb begin
		if (pal[3]) begin
			pal_base = pal[0] ? sprc_pkg::ADDR_PAL4_B : sprc_pkg::ADDR_PAL4_A;
			mask     = 8'h03;
			shift    = {pal[2:1], 1'b0};
		end else if (pal[2]) begin
			pal_base = pal[0] ? sprc_pkg::ADDR_PAL16_B : sprc_pkg::ADDR_PAL16_A;
			mask     = 8'h0f;
			shift    = pal[1] ? 3'd4 : 3'd0;
		end else begin
			pal_base = sprc_pkg::ADDR_PAL256 + {22'd0, pal[1:0], 8'h00};
			mask     = 8'hff;
			shift    = 3'd0;
		end
	end

	assign idx      = (vm_rdata >> shift) & mask;
	assign pal_addr = AW'(pal_base + {23'd0, idx, 1'b0});
	assign img_addr = AW'(32'(sprc_pkg::SPRITE_IMAGE_BASE) + {18'd0, image, row_q, sx_q});
	assign rec_addr = (k_q == 3'd4) ? AW'(sprc_pkg::ADDR_JK_MODE) :
		AW'(32'(sprc_pkg::SPRITE_TABLE_BASE) + {22'd0, spr_q, 2'b00} + {29'd0, k_q});
	assign jk2_addr = AW'(32'(sprc_pkg::SPRITE_TABLE_BASE) + {21'd0, ow_rdata, 2'b11});
	assign coll_addr = AW'(32'(sprc_pkg::ADDR_COLLIDE) + {24'd0, spr_q});

	// Sweep: owner map to empty; on reset zero video memory, on frame set collisions
	assign sweep_own  = {1'b0, sweep_q} < (CW + 1)'(sprc_pkg::OWNER_DEPTH);
	assign sweep_vm   = wipe_all_q ?
		({1'b0, sweep_q} < (CW + 1)'(sprc_pkg::VIDEO_MEMORY_BYTES)) :
		({1'b0, sweep_q} < (CW + 1)'(256));
	assign sweep_addr = wipe_all_q ? sweep_q[AW-1:0] :
		AW'(32'(sprc_pkg::ADDR_COLLIDE) + {24'd0, sweep_q[7:0]});
	assign sweep_end  = sweep_q == CW'(sprc_pkg::CLR_LEN - 1);

	assign collide = !jkmode_q || (jk ^ vm_rdata[7]);

	// Next state and memory controls
	always_comb begin
		nxt      = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		vm_we    = 1'b0;
		vm_addr  = AW'(addr_q);
		vm_wdata = wdata_q;
		ow_we    = 1'b0;
		ow_addr  = cell_q;
		ow_wdata = {1'b0, spr_q};
		unique case (state_q)
			sprc_pkg::ST_CLR: begin
				ow_we    = sweep_own;
				ow_addr  = sweep_q[OW-1:0];
				ow_wdata = sprc_pkg::OWNER_EMPTY;
				vm_we    = sweep_vm;
				vm_addr  = sweep_addr;
				vm_wdata = wipe_all_q ? 8'h00 : 8'hff;
				if (sweep_end) begin
					nxt = sprc_pkg::ST_IDLE;
				end
			end
			sprc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (accept) begin
					unique case (sprc_pkg::cmd_t'(cmd))
						sprc_pkg::CMD_WRITE: nxt = sprc_pkg::ST_WR;
						sprc_pkg::CMD_READ:  nxt = sprc_pkg::ST_RD;
						sprc_pkg::CMD_RENDER: begin
							if ({1'b0, sprite_index} < 9'(sprc_pkg::SPRITE_COUNT)) begin
								nxt = sprc_pkg::ST_REC;
							end
						end
						default: nxt = sprc_pkg::ST_CLR;
					endcase
				end
			end
			sprc_pkg::ST_WR: begin
				vm_we = 1'b1;
				nxt   = sprc_pkg::ST_IDLE;
			end
			sprc_pkg::ST_RD: nxt = sprc_pkg::ST_RD_D;
			sprc_pkg::ST_RD_D: nxt = sprc_pkg::ST_OUT;
			sprc_pkg::ST_REC: begin
				vm_addr = rec_addr;
				nxt     = sprc_pkg::ST_REC_D;
			end
			sprc_pkg::ST_REC_D: begin
				nxt = (k_q == 3'd4) ? sprc_pkg::ST_POS : sprc_pkg::ST_REC;
			end
			sprc_pkg::ST_POS: begin
				vm_addr = img_addr;
				nxt     = onscreen ? sprc_pkg::ST_IMG : sprc_pkg::ST_OUT;
			end
			sprc_pkg::ST_IMG: begin
				vm_addr = pal_addr;
				nxt     = sprc_pkg::ST_CLO;
			end
			sprc_pkg::ST_CLO: begin
				vm_addr = ca_q + AW'(1);
				nxt     = sprc_pkg::ST_CHI;
			end
			sprc_pkg::ST_CHI: begin
				// Bit 15 set: transparent, leave owner map alone
				nxt = vm_rdata[7] ? sprc_pkg::ST_OUT : sprc_pkg::ST_OWN;
			end
			sprc_pkg::ST_OWN: begin
				ow_we   = 1'b1;
				vm_addr = jk2_addr;
				nxt     = (ow_rdata != sprc_pkg::OWNER_EMPTY) ? sprc_pkg::ST_JK :
					sprc_pkg::ST_OUT;
			end
			sprc_pkg::ST_JK: begin
				vm_we    = collide;
				vm_addr  = coll_addr;
				vm_wdata = other_q[7:0];
				nxt      = sprc_pkg::ST_OUT;
			end
			sprc_pkg::ST_OUT: begin
				if (can_load) begin
					out_load = 1'b1;
					nxt = (cmd_q == sprc_pkg::CMD_READ || sx_q == 4'd15) ?
						sprc_pkg::ST_IDLE : sprc_pkg::ST_POS;
				end
			end
			default: nxt = sprc_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sprc_pkg::ST_CLR;
			sweep_q    <= '0;
			wipe_all_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (state_q == sprc_pkg::ST_CLR) begin
				sweep_q <= sweep_end ? '0 : sweep_q + CW'(1);
				if (sweep_end) begin
					wipe_all_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			sprc_pkg::ST_IDLE: begin
				cmd_q   <= sprc_pkg::cmd_t'(cmd);
				addr_q  <= address;
				wdata_q <= write_data;
				spr_q   <= sprite_index;
				row_q   <= source_row;
				k_q     <= 3'd0;
				sx_q    <= 4'd0;
				drawn_q <= 1'b0;
			end
			sprc_pkg::ST_RD_D: color_q[7:0] <= vm_rdata;
			sprc_pkg::ST_REC_D: begin
				if (k_q == 3'd4) begin
					jkmode_q <= |vm_rdata;
				end else begin
					rec_q <= {vm_rdata, rec_q[31:8]};
				end
				k_q <= k_q + 3'd1;
			end
			sprc_pkg::ST_POS: begin
				wx_q    <= wx;
				wy_q    <= wy;
				cell_q  <= cell_idx;
				drawn_q <= 1'b0;
			end
			sprc_pkg::ST_IMG: ca_q <= pal_addr;
			sprc_pkg::ST_CLO: color_q[7:0] <= vm_rdata;
			sprc_pkg::ST_CHI: color_q[15:8] <= vm_rdata;
			sprc_pkg::ST_OWN: begin
				other_q <= ow_rdata;
				drawn_q <= 1'b1;
			end
			sprc_pkg::ST_OUT: begin
				if (out_load) begin
					sx_q <= sx_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// Output register: hold while stalled, load the next transaction when free
	always_ff @(posedge clk) begin
		if (out_load) begin
			read_data_q   <= (cmd_q == sprc_pkg::CMD_READ) ? color_q[7:0] : 8'd0;
			pixel_x_q     <= drawn_q ? wx_q : 9'd0;
			pixel_y_q     <= drawn_q ? wy_q : 9'd0;
			color_out_q   <= drawn_q ? color_q[14:0] : 15'd0;
			pixel_drawn_q <= drawn_q;
			last_q        <= (cmd_q == sprc_pkg::CMD_READ) || (sx_q == 4'd15);
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign color       = color_out_q;
	assign pixel_drawn = pixel_drawn_q;
	assign last        = last_q;

endmodule

@@ dv/tb_sprite_rasterizer_with_collision.sv @@
module tb_sprite_rasterizer_with_collision;

	// One transaction on the result channel.
	typedef struct packed {
		logic [7:0]  read_data;
		logic [8:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [14:0] color;
		logic        pixel_drawn;
		logic        last;
	} pix_t;

	// Mirror of video memory and pixel owner map; predicts every result transaction.
	class raster_model;
		logic [7:0] vram[sprc_pkg::VIDEO_MEMORY_BYTES];
		logic [8:0] owner[sprc_pkg::OWNER_DEPTH];
		pix_t       pending[$];
		int         mismatches;
		int         checked;
		int         drawn_seen;

		function new();
			foreach (vram[i]) vram[i] = 8'h00;
			foreach (owner[i]) owner[i] = sprc_pkg::OWNER_EMPTY;
			mismatches = 0;
			checked = 0;
			drawn_seen = 0;
		endfunction

		function logic [7:0] rd(int a);
			return vram[a % sprc_pkg::VIDEO_MEMORY_BYTES];
		endfunction

		function void draw_row(int spr, int row);
			int rec, x, y, rot, pal, image, jk, pal_base, mask, shift;
			int rx, ry, t, wx, wy, pix, ca, cell_idx, other, jk2;
			logic [15:0] c;
			pix_t p;
			rec = sprc_pkg::SPRITE_TABLE_BASE + 4 * spr;
			x = rd(rec) | ((rd(rec + 1) & 1) << 8);
			y = rd(rec + 2) | ((rd(rec + 3) & 1) << 8);
			rot = (rd(rec + 1) & 8'h0e) >> 1;
			pal = (rd(rec + 1) & 8'hf0) >> 4;
			image = (rd(rec + 3) & 8'h7e) >> 1;
			jk = (rd(rec + 3) & 8'h80) >> 7;
			if (pal & 8) begin
				pal_base = (pal & 1) ? sprc_pkg::ADDR_PAL4_B : sprc_pkg::ADDR_PAL4_A;
				mask = 3;
				shift = ((pal >> 1) & 3) * 2;
			end else if (pal & 4) begin
				pal_base = (pal & 1) ? sprc_pkg::ADDR_PAL16_B : sprc_pkg::ADDR_PAL16_A;
				mask = 15;
				shift = (pal & 2) ? 4 : 0;
			end else begin
				pal_base = sprc_pkg::ADDR_PAL256 + ((pal & 3) << 8);
				mask = 255;
				shift = 0;
			end
			for (int sx = 0; sx < 16; sx++) begin
				p = '0;
				rx = sx;
				ry = row;
				if (rot & 4) ry = 15 - ry;
				if (rot & 2) rx = 15 - rx;
				if (rot & 1) begin
					t = rx; rx = ry; ry = t;
				end
				wx = (x + rx) & 9'h1ff;
				wy = (y + ry) & 9'h1ff;
				if (wx < sprc_pkg::SCREEN_WIDTH && wy < sprc_pkg::SCREEN_HEIGHT) begin
					pix = rd(sprc_pkg::SPRITE_IMAGE_BASE + (image << 8) + ((row << 4) | sx));
					ca = pal_base + 2 * ((pix >> shift) & mask);
					c = {rd(ca + 1), rd(ca)};
					if (!c[15]) begin
						cell_idx = wy * sprc_pkg::SCREEN_WIDTH + wx;
						other = owner[cell_idx];
						if (other != sprc_pkg::OWNER_EMPTY) begin
							jk2 = rd(sprc_pkg::SPRITE_TABLE_BASE + 4 * other + 3) >> 7;
							if (rd(sprc_pkg::ADDR_JK_MODE) == 0 || jk != jk2)
								vram[(sprc_pkg::ADDR_COLLIDE + spr) %
									sprc_pkg::VIDEO_MEMORY_BYTES] = other[7:0];
						end
						owner[cell_idx] = spr[8:0];
						p.pixel_x = wx[8:0];
						p.pixel_y = wy[8:0];
						p.color = c[14:0];
						p.pixel_drawn = 1'b1;
					end
				end
				p.last = (sx == 15);
				pending.push_back(p);
			end
		endfunction

		// Note one accepted input transaction.
		function void note_item(sprc_pkg::cmd_t c, int a, logic [7:0] d, int spr, int row);
			pix_t p;
			case (c)
				sprc_pkg::CMD_WRITE: vram[a % sprc_pkg::VIDEO_MEMORY_BYTES] = d;
				sprc_pkg::CMD_READ: begin
					p = '0;
					p.read_data = rd(a);
					p.last = 1'b1;
					pending.push_back(p);
				end
				sprc_pkg::CMD_RENDER: if (spr < sprc_pkg::SPRITE_COUNT) draw_row(spr, row);
				default: begin
					foreach (owner[i]) owner[i] = sprc_pkg::OWNER_EMPTY;
					for (int i = 0; i < 256; i++)
						vram[(sprc_pkg::ADDR_COLLIDE + i) % sprc_pkg::VIDEO_MEMORY_BYTES] = 8'hff;
				end
			endcase
		endfunction

		// Compare one accepted result transaction with the oldest expectation.
		function void check_pixel(pix_t got);
			pix_t exp_p;
			checked++;
			if (got.pixel_drawn) drawn_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transaction %h", got);
				return;
			end
			exp_p = pending.pop_front();
			if (got !== exp_p) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp rd=%h x=%0d y=%0d c=%h d=%b l=%b",
						exp_p.read_data, exp_p.pixel_x, exp_p.pixel_y, exp_p.color,
						exp_p.pixel_drawn, exp_p.last);
					$display("          got rd=%h x=%0d y=%0d c=%h d=%b l=%b",
						got.read_data, got.pixel_x, got.pixel_y, got.color,
						got.pixel_drawn, got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  cmd;
	logic [14:0] address;
	logic [7:0]  write_data;
	logic [7:0]  sprite_index;
	logic [3:0]  source_row;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic [8:0]  pixel_x;
	logic [8:0]  pixel_y;
	logic [14:0] color;
	logic        pixel_drawn;
	logic        last;

	raster_model model;
	bit          calm;    // suppress random idling on both sides
	int          frames;

	sprite_rasterizer_with_collision u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .address(address), .write_data(write_data),
		.sprite_index(sprite_index), .source_row(source_row),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.color(color), .pixel_drawn(pixel_drawn), .last(last)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Receiver: stall at random unless in a calm stretch.
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25);
	end

	// Monitor: take every accepted result transaction to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			model.check_pixel({read_data, pixel_x, pixel_y, color, pixel_drawn, last});
	end

	// Drive one input transaction and hold it until accepted.
	task automatic send(sprc_pkg::cmd_t c, int a = 0, int d = 0, int spr = 0, int row = 0);
		while (!calm && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		address      <= a[14:0];
		write_data   <= d[7:0];
		sprite_index <= spr[7:0];
		source_row   <= row[3:0];
		do @(posedge clk); while (in_stall);
		model.note_item(c, int'(a[14:0]), d[7:0], int'(spr[7:0]), int'(row[3:0]));
		if (c == sprc_pkg::CMD_FRAME) frames++;
	endtask

	task automatic put_record(int spr, int b0, int b1, int b2, int b3);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::SPRITE_TABLE_BASE + 4 * spr, b0);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::SPRITE_TABLE_BASE + 4 * spr + 1, b1);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::SPRITE_TABLE_BASE + 4 * spr + 2, b2);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::SPRITE_TABLE_BASE + 4 * spr + 3, b3);
	endtask

	initial begin
		int spr, pick;
		model = new();
		calm = 1'b0;
		frames = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = sprc_pkg::CMD_WRITE;
		address = '0;
		write_data = '0;
		sprite_index = '0;
		source_row = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: sprite 3 in 4-color mode with every flip and transpose, x wrapping
		// past 511 so part of the row falls off screen, color index 0 transparent.
		put_record(3, 8'hf8, 8'hcf, 8'd10, 8'h82);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::SPRITE_IMAGE_BASE + 256 + 8'h20, 8'hff);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::ADDR_PAL4_A + 6, 8'hff);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::ADDR_PAL4_A + 7, 8'h7f);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::ADDR_PAL4_A + 1, 8'h80);
		send(sprc_pkg::CMD_RENDER, 0, 0, 3, 2);
		send(sprc_pkg::CMD_RENDER, 0, 0, 3, 2);     // same row again: self collision
		// Sprite 255 near the bottom right corner, 256-color palette, jk 0.
		put_record(255, 8'h8b, 8'h01, 8'h22, 8'h01);
		send(sprc_pkg::CMD_RENDER, 0, 0, 255, 0);
		send(sprc_pkg::CMD_RENDER, 0, 0, 255, 15);
		send(sprc_pkg::CMD_WRITE, sprc_pkg::ADDR_JK_MODE, 8'h01);
		send(sprc_pkg::CMD_RENDER, 0, 0, 255, 0);   // equal jk bits: no collision recorded
		send(sprc_pkg::CMD_READ, sprc_pkg::ADDR_COLLIDE + 3);
		send(sprc_pkg::CMD_READ, sprc_pkg::ADDR_COLLIDE + 255);
		send(sprc_pkg::CMD_WRITE, 15'h7fff, 8'ha5);
		send(sprc_pkg::CMD_READ, 15'h7fff);
		send(sprc_pkg::CMD_READ, 15'h0000);
		send(sprc_pkg::CMD_FRAME);
		send(sprc_pkg::CMD_READ, sprc_pkg::ADDR_COLLIDE);

		// Random: mostly record, palette and image writes followed by renders of the
		// same few sprites, with noise writes and reads across the whole space and occasional start frames.
		for (int n = 0; n < 65; n++) begin
			calm = (n >= 20 && n < 40);
			spr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send(sprc_pkg::CMD_RENDER, $urandom, $urandom, spr, $urandom_range(0, 15));
			else if (pick < 50)
				put_record(spr, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 62)
				send(sprc_pkg::CMD_WRITE, sprc_pkg::ADDR_JK_MODE - 8 + $urandom_range(0, 255),
					$urandom);
			else if (pick < 70)
				send(sprc_pkg::CMD_WRITE, sprc_pkg::ADDR_PAL256 + $urandom_range(0, 1023),
					$urandom);
			else if (pick < 80)
				send(sprc_pkg::CMD_WRITE, sprc_pkg::SPRITE_IMAGE_BASE + $urandom_range(0, 16383),
					$urandom);
			else if (pick < 90)
				send(sprc_pkg::CMD_READ, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 98 || frames >= 3)
				send(sprc_pkg::CMD_WRITE, $urandom, $urandom, $urandom, $urandom);
			else
				send(sprc_pkg::CMD_FRAME, $urandom, $urandom, $urandom, $urandom);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (model.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("checked %0d result transactions, %0d drawn pixels, %0d frame starts",
			model.checked, model.drawn_seen, frames);
		if (model.mismatches == 0) begin
			$display("tb_sprite_rasterizer_with_collision OK");
		end else begin
			$display("%0d mismatches", model.mismatches);
			$display("tb_sprite_rasterizer_with_collision NOT OK");
		end
		$finish;
	end

	// Hard stop: several times the slowest legal run, clearing sweeps included.
	initial begin
		#30000000;
		$display("timeout");
		$display("tb_sprite_rasterizer_with_collision NOT OK");
		$finish;
	end

endmodule
